@@ rtl/kmc_pkg.sv @@
// Shared constants and types for the k-means clustering block.
`timescale 1ns / 1ps
package kmc_pkg;
    localparam int MAX_POINTS   = 48;
    localparam int MAX_CLUSTERS = 8;
    localparam int COORD_BITS   = 16;
    localparam int PIDX_BITS    = $clog2(MAX_POINTS);
    localparam int PCNT_BITS    = $clog2(MAX_POINTS + 1);
    localparam int CIDX_BITS    = $clog2(MAX_CLUSTERS);
    localparam int SUM_BITS     = COORD_BITS + PCNT_BITS;
    localparam int DIST_BITS    = 2 * COORD_BITS + 1;

    localparam logic [1:0] FUNC_LOAD_POINT = 2'd0;
    localparam logic [1:0] FUNC_LOAD_SEED  = 2'd1;
    localparam logic [1:0] FUNC_START      = 2'd2;

    localparam logic [0:0] REG_CLUSTER_COUNT = 1'd0;
    localparam logic [0:0] REG_MAX_PASSES    = 1'd1;

    // Command handed from the front to the back through the queue
    typedef struct packed {
        logic [1:0]            func;
        logic [2:0]            slot;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_cmd;
endpackage

@@ rtl/kmeans_point_clustering.sv @@
// Top level of the k-means point clustering block.
// Load beats: accepted one per cycle while the queue has room, retired by the back end while idle.
// Start: each pass assigns every point to its nearest centroid, then divides the sums per cluster and
// checks convergence; point results follow, then centroid results one per cycle when ready.
// Throughput is set by the distance loop and the bit-serial divider.
// Synchronous active-low reset clears control and centroids and loads the register defaults.
`timescale 1ns / 1ps
module kmeans_point_clustering (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [2:0]  i_slot,
    input  logic [15:0] i_coord_x,
    input  logic [15:0] i_coord_y,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [5:0]  o_item_index,
    output logic [2:0]  o_cluster_id,
    output logic [15:0] o_centre_x,
    output logic [15:0] o_centre_y,
    output logic        o_converged,
    output logic [7:0]  o_passes_used,
    output logic        o_last
);
    logic [3:0] r_cluster_count;
    logic [7:0] r_max_passes;
    logic cmd_valid, cmd_ready;
    kmc_pkg::t_cmd cmd;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_count <= 4'd4;
            r_max_passes    <= 8'd64;
        end else if (i_cfg_we) begin
            if (i_cfg_index == kmc_pkg::REG_CLUSTER_COUNT) r_cluster_count <= i_cfg_data[3:0];
            else                                           r_max_passes    <= i_cfg_data;
        end
    end

    kmc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_func, .i_slot, .i_coord_x, .i_coord_y,
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    kmc_back u_back (
        .i_clk, .i_rst_n,
        .i_cluster_count(r_cluster_count), .i_max_passes(r_max_passes),
        .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .o_valid, .i_ready, .o_kind, .o_item_index, .o_cluster_id,
        .o_centre_x, .o_centre_y, .o_converged, .o_passes_used, .o_last
    );
endmodule

@@ rtl/kmc_front.sv @@
// Front end: accepts input beats, drops unused codes, queues commands.
`timescale 1ns / 1ps
module kmc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic [2:0]         i_slot,
    input  logic [15:0]        i_coord_x,
    input  logic [15:0]        i_coord_y,
    output logic               o_cmd_valid,
    input  logic               i_cmd_ready,
    output kmc_pkg::t_cmd      o_cmd
);
    kmc_pkg::t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop, useful;

    assign useful      = (i_func == kmc_pkg::FUNC_LOAD_POINT) ||
                         (i_func == kmc_pkg::FUNC_LOAD_SEED) ||
                         (i_func == kmc_pkg::FUNC_START);
    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready && useful;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    // Two-entry command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{func: i_func, slot: i_slot, x: i_coord_x, y: i_coord_y};
        end
    end
endmodule

@@ rtl/kmc_back.sv @@
// Back end: point store, Lloyd passes, centroid update, result stream.
`timescale 1ns / 1ps
module kmc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [3:0]          i_cluster_count,
    input  logic [7:0]          i_max_passes,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  kmc_pkg::t_cmd       i_cmd,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_kind,
    output logic [5:0]          o_item_index,
    output logic [2:0]          o_cluster_id,
    output logic [15:0]         o_centre_x,
    output logic [15:0]         o_centre_y,
    output logic                o_converged,
    output logic [7:0]          o_passes_used,
    output logic                o_last
);
    localparam int CB = kmc_pkg::COORD_BITS;
    localparam int PB = kmc_pkg::PIDX_BITS;
    localparam int NB = kmc_pkg::PCNT_BITS;
    localparam int KB = kmc_pkg::CIDX_BITS;
    localparam int SB = kmc_pkg::SUM_BITS;
    localparam int DB = kmc_pkg::DIST_BITS;
    localparam int NC = kmc_pkg::MAX_CLUSTERS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PRD   = 4'd1;  // issue point read
    localparam logic [3:0] S_PWAIT = 4'd2;  // point data arrives
    localparam logic [3:0] S_DIST  = 4'd3;  // square stage, one centroid at a time
    localparam logic [3:0] S_ACC   = 4'd4;  // compare distance, or accumulate into best cluster
    localparam logic [3:0] S_DIV   = 4'd5;  // restoring division per cluster
    localparam logic [3:0] S_CHK   = 4'd6;  // quotient write-back and convergence check
    localparam logic [3:0] S_ORD   = 4'd7;  // read cluster id for output
    localparam logic [3:0] S_OPT   = 4'd8;  // point result out
    localparam logic [3:0] S_OCT   = 4'd9;  // centroid result out
    localparam logic [3:0] S_SQ    = 4'd10; // difference stage

    logic [3:0] r_st;
    logic [CB-1:0] r_px [kmc_pkg::MAX_POINTS];
    logic [CB-1:0] r_py [kmc_pkg::MAX_POINTS];
    logic [KB-1:0] r_pc [kmc_pkg::MAX_POINTS];
    logic [CB-1:0] r_rx, r_ry;
    logic [KB-1:0] r_rc;
    logic [NB-1:0] r_npts;
    logic [CB-1:0] r_cx [NC], r_cy [NC], r_qx [NC], r_qy [NC];
    logic [SB-1:0] r_sx [NC], r_sy [NC];
    logic [NB-1:0] r_mc [NC];
    logic          r_pv;
    logic [KB:0]   r_k;
    logic [7:0]    r_lim, r_pass;
    logic [PB-1:0] r_pi;
    logic [KB:0]   r_j;
    logic [KB-1:0] r_best;
    logic [DB-1:0] r_bd;
    logic [CB-1:0] r_dx, r_dy;
    logic [2*CB-1:0] r_ax, r_ay;
    logic          r_sqv;
    logic [KB-1:0] r_sqj;
    logic [SB-1:0] r_nx, r_ny, r_remx, r_remy;
    logic [SB-1:0] r_quox, r_quoy;
    logic [$clog2(SB+1)-1:0] r_bit;
    logic          r_conv;
    logic          r_ov;
    logic          r_okind, r_olast;
    logic [5:0]    r_oidx;
    logic [2:0]    r_ocid;
    logic [15:0]   r_oxo, r_oyo;
    logic          r_oconv;
    logic [7:0]    r_opass;

    logic [KB-1:0] jj;
    logic [DB-1:0] sq_sum;
    logic          out_free;
    logic          out_load;
    logic [SB:0]   trx, try_;
    logic [SB-1:0] shx, shy;
    logic          same;
    logic [KB:0]   kk;
    logic [7:0]    lim;

    assign jj       = r_j[KB-1:0];
    assign sq_sum   = {1'b0, r_ax} + {1'b0, r_ay};
    assign out_free = !r_ov || i_ready;
    assign out_load = out_free && (r_st == S_OPT || r_st == S_OCT);
    assign o_cmd_ready = (r_st == S_IDLE);
    assign kk  = (i_cluster_count == 4'd0) ? (KB+1)'(1) :
                 (i_cluster_count > 4'(NC)) ? (KB+1)'(NC) : (KB+1)'(i_cluster_count);
    assign lim = (i_max_passes == 8'd0) ? 8'd1 : i_max_passes;

    assign shx  = {r_remx[SB-2:0], r_nx[SB-1]};
    assign shy  = {r_remy[SB-2:0], r_ny[SB-1]};
    assign trx  = {1'b0, shx} - {{(SB-NB+1){1'b0}}, r_mc[jj]};
    assign try_ = {1'b0, shy} - {{(SB-NB+1){1'b0}}, r_mc[jj]};

    // Compare current and previous centroids for active clusters
    always_comb begin
        same = 1'b1;
        for (int c = 0; c < NC; c++) begin
            if (c < r_k && (r_cx[c] != r_qx[c] || r_cy[c] != r_qy[c])) same = 1'b0;
        end
    end

    // Point memories, registered read
    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_cmd_valid && i_cmd.func == kmc_pkg::FUNC_LOAD_POINT
            && r_npts < NB'(kmc_pkg::MAX_POINTS)) begin
            r_px[r_npts[PB-1:0]] <= i_cmd.x;
            r_py[r_npts[PB-1:0]] <= i_cmd.y;
        end
        if (r_st == S_ACC) r_pc[r_pi] <= r_best;
        r_rx <= r_px[r_pi];
        r_ry <= r_py[r_pi];
        r_rc <= r_pc[r_pi];
    end

    // Output valid: raise on a new beat, drop once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    // Sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_npts <= '0;
            r_pv   <= 1'b0;
            r_sqv  <= 1'b0;
            for (int c = 0; c < NC; c++) begin
                r_cx[c] <= '0; r_cy[c] <= '0; r_qx[c] <= '0; r_qy[c] <= '0;
                r_sx[c] <= '0; r_sy[c] <= '0; r_mc[c] <= '0;
            end
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        case (i_cmd.func)
                            kmc_pkg::FUNC_LOAD_POINT: begin
                                if (r_npts < NB'(kmc_pkg::MAX_POINTS)) r_npts <= r_npts + 1'b1;
                            end
                            kmc_pkg::FUNC_LOAD_SEED: begin
                                r_cx[i_cmd.slot[KB-1:0]] <= i_cmd.x;
                                r_cy[i_cmd.slot[KB-1:0]] <= i_cmd.y;
                            end
                            kmc_pkg::FUNC_START: begin
                                r_k    <= kk;
                                r_lim  <= lim;
                                r_pass <= 8'd1;
                                r_pv   <= 1'b0;
                                r_pi   <= '0;
                                for (int c = 0; c < NC; c++) begin
                                    r_sx[c] <= '0; r_sy[c] <= '0; r_mc[c] <= '0;
                                end
                                r_st <= (r_npts == '0) ? S_DIV : S_PRD;
                                r_j  <= '0;
                                r_bit <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_PRD: r_st <= S_PWAIT;
                S_PWAIT: begin
                    r_j   <= '0;
                    r_sqv <= 1'b0;
                    r_st  <= S_SQ;
                end
                S_SQ: begin
                    // difference stage, then square stage, then compare
                    if (r_j < r_k) begin
                        r_dx <= (r_rx > r_cx[jj]) ? r_rx - r_cx[jj] : r_cx[jj] - r_rx;
                        r_dy <= (r_ry > r_cy[jj]) ? r_ry - r_cy[jj] : r_cy[jj] - r_ry;
                        r_j  <= r_j + 1'b1;
                        r_sqj <= jj;
                    end
                    r_sqv <= (r_j < r_k);
                    r_st  <= S_DIST;
                end
                S_DIST: begin
                    r_ax <= r_dx * r_dx;
                    r_ay <= r_dy * r_dy;
                    if (r_sqv) begin
                        r_st <= S_ACC;
                    end else begin
                        r_st <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_sqv) begin
                        if (r_sqj == '0 || sq_sum < r_bd) begin
                            r_bd   <= sq_sum;
                            r_best <= r_sqj;
                        end
                        r_st <= S_SQ;
                    end else begin
                        r_sx[r_best] <= r_sx[r_best] + SB'(r_rx);
                        r_sy[r_best] <= r_sy[r_best] + SB'(r_ry);
                        r_mc[r_best] <= r_mc[r_best] + 1'b1;
                        if (NB'(r_pi) + 1'b1 == r_npts) begin
                            r_j   <= '0;
                            r_bit <= '0;
                            r_st  <= S_DIV;
                        end else begin
                            r_pi <= r_pi + 1'b1;
                            r_st <= S_PRD;
                        end
                    end
                end
                S_DIV: begin
                    // one quotient bit per cycle for both axes
                    if (r_bit == '0) begin
                        r_nx <= r_sx[jj]; r_ny <= r_sy[jj];
                        r_remx <= '0; r_remy <= '0;
                        r_bit <= r_bit + 1'b1;
                    end else begin
                        r_nx <= {r_nx[SB-2:0], 1'b0};
                        r_ny <= {r_ny[SB-2:0], 1'b0};
                        r_remx <= trx[SB] ? shx : trx[SB-1:0];
                        r_remy <= try_[SB] ? shy : try_[SB-1:0];
                        r_quox <= {r_quox[SB-2:0], ~trx[SB]};
                        r_quoy <= {r_quoy[SB-2:0], ~try_[SB]};
                        if (r_bit == SB) begin
                            r_bit <= '0;
                            r_st  <= S_CHK;
                        end else begin
                            r_bit <= r_bit + 1'b1;
                        end
                    end
                end
                S_CHK: begin
                    if (r_j < r_k) begin
                        // write back this cluster's quotients, then next cluster
                        r_cx[jj] <= (r_mc[jj] == '0) ? '0 : r_quox[CB-1:0];
                        r_cy[jj] <= (r_mc[jj] == '0) ? '0 : r_quoy[CB-1:0];
                        r_j  <= r_j + 1'b1;
                        r_st <= ((r_j + 1'b1) < r_k) ? S_DIV : S_CHK;
                    end else begin
                        r_j <= '0;
                        if (r_pv && same) begin
                            r_conv <= 1'b1;
                            r_pi   <= '0;
                            r_st   <= (r_npts == '0) ? S_OCT : S_ORD;
                        end else begin
                            for (int c = 0; c < NC; c++) begin
                                if (c < r_k) begin r_qx[c] <= r_cx[c]; r_qy[c] <= r_cy[c]; end
                            end
                            r_pv <= 1'b1;
                            if (r_pass >= r_lim) begin
                                r_conv <= 1'b0;
                                r_pi   <= '0;
                                r_st   <= (r_npts == '0) ? S_OCT : S_ORD;
                            end else begin
                                r_pass <= r_pass + 1'b1;
                                r_pi   <= '0;
                                for (int c = 0; c < NC; c++) begin
                                    r_sx[c] <= '0; r_sy[c] <= '0; r_mc[c] <= '0;
                                end
                                r_st <= (r_npts == '0) ? S_DIV : S_PRD;
                            end
                        end
                    end
                end
                S_ORD: r_st <= S_OPT;
                S_OPT: begin
                    if (out_free) begin
                        r_okind <= 1'b0;
                        r_oidx  <= 6'(r_pi);
                        r_ocid  <= 3'(r_rc);
                        r_oxo   <= '0;
                        r_oyo   <= '0;
                        r_oconv <= r_conv;
                        r_opass <= r_pass;
                        r_olast <= 1'b0;
                        if (NB'(r_pi) + 1'b1 == r_npts) begin
                            r_st <= S_OCT;
                        end else begin
                            r_pi <= r_pi + 1'b1;
                            r_st <= S_ORD;
                        end
                    end
                end
                S_OCT: begin
                    if (out_free) begin
                        r_okind <= 1'b1;
                        r_oidx  <= 6'(jj);
                        r_ocid  <= '0;
                        r_oxo   <= r_cx[jj];
                        r_oyo   <= r_cy[jj];
                        r_oconv <= r_conv;
                        r_opass <= r_pass;
                        r_olast <= (r_j + 1'b1 == r_k);
                        r_j     <= r_j + 1'b1;
                        if (r_j + 1'b1 == r_k) r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_ov;
    assign o_kind        = r_okind;
    assign o_item_index  = r_oidx;
    assign o_cluster_id  = r_ocid;
    assign o_centre_x    = r_oxo;
    assign o_centre_y    = r_oyo;
    assign o_converged   = r_oconv;
    assign o_passes_used = r_opass;
    assign o_last        = r_olast;
endmodule

@@ dv/tb.sv @@
// Testbench for the k-means point clustering block: directed and random runs.
`timescale 1ns / 1ps
module tb;
    localparam logic [1:0] FUNC_UNUSED   = 2'd3;
    localparam int         DRAIN_CYCLES  = 300;
    localparam int         STALL_LIMIT   = 2000000;

    typedef struct packed {
        logic        kind;
        logic [5:0]  idx;
        logic [2:0]  cid;
        logic [15:0] cx;
        logic [15:0] cy;
        logic        conv;
        logic [7:0]  passes;
        logic        last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_func = '0;
    logic [2:0]  i_slot = '0;
    logic [15:0] i_coord_x = '0;
    logic [15:0] i_coord_y = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_kind;
    logic [5:0]  o_item_index;
    logic [2:0]  o_cluster_id;
    logic [15:0] o_centre_x;
    logic [15:0] o_centre_y;
    logic        o_converged;
    logic [7:0]  o_passes_used;
    logic        o_last;

    kmeans_point_clustering dut (.*);

    always #10 i_clk = ~i_clk;

    // Predictor state
    logic [15:0] pt_x [kmc_pkg::MAX_POINTS];
    logic [15:0] pt_y [kmc_pkg::MAX_POINTS];
    logic [2:0]  pt_cl [kmc_pkg::MAX_POINTS];
    int          pt_n = 0;
    logic [15:0] ctr_x [kmc_pkg::MAX_CLUSTERS] = '{default: '0};
    logic [15:0] ctr_y [kmc_pkg::MAX_CLUSTERS] = '{default: '0};
    logic [3:0]  k_reg = 4'd4;
    logic [7:0]  limit_reg = 8'd64;

    t_result pending_results [$];
    int      errors = 0;
    int      useful_beats = 0;
    int      hold_cycles = 0;
    bit      calm = 1'b0;
    bit      valid_held = 1'b0;

    function automatic logic [32:0] sq_dist(logic [15:0] ax, logic [15:0] ay,
                                            logic [15:0] bx, logic [15:0] by);
        logic [15:0] dx;
        logic [15:0] dy;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        return 33'(dx) * 33'(dx) + 33'(dy) * 33'(dy);
    endfunction

    // Run Lloyd passes on the model state and queue the expected beats
    task automatic predict_clustering();
        int          k;
        int          lim;
        int          passes;
        bit          conv;
        bit          prev_ok;
        bit          same;
        int          best;
        logic [32:0] bd;
        logic [32:0] d;
        logic [21:0] sx [kmc_pkg::MAX_CLUSTERS];
        logic [21:0] sy [kmc_pkg::MAX_CLUSTERS];
        int          cnt [kmc_pkg::MAX_CLUSTERS];
        logic [15:0] px [kmc_pkg::MAX_CLUSTERS];
        logic [15:0] py [kmc_pkg::MAX_CLUSTERS];
        t_result     r;
        k = (k_reg == 0) ? 1 : (k_reg > kmc_pkg::MAX_CLUSTERS) ? kmc_pkg::MAX_CLUSTERS :
            int'(k_reg);
        lim = (limit_reg == 0) ? 1 : int'(limit_reg);
        passes = 0;
        conv = 1'b0;
        prev_ok = 1'b0;
        forever begin
            passes++;
            for (int j = 0; j < k; j++) begin
                sx[j] = '0;
                sy[j] = '0;
                cnt[j] = 0;
            end
            for (int i = 0; i < pt_n; i++) begin
                best = 0;
                bd = sq_dist(pt_x[i], pt_y[i], ctr_x[0], ctr_y[0]);
                for (int j = 1; j < k; j++) begin
                    d = sq_dist(pt_x[i], pt_y[i], ctr_x[j], ctr_y[j]);
                    if (d < bd) begin
                        bd = d;
                        best = j;
                    end
                end
                pt_cl[i] = 3'(best);
                sx[best] += pt_x[i];
                sy[best] += pt_y[i];
                cnt[best]++;
            end
            same = 1'b1;
            for (int j = 0; j < k; j++) begin
                ctr_x[j] = (cnt[j] == 0) ? 16'd0 : 16'(sx[j] / cnt[j]);
                ctr_y[j] = (cnt[j] == 0) ? 16'd0 : 16'(sy[j] / cnt[j]);
                if (ctr_x[j] != px[j] || ctr_y[j] != py[j]) same = 1'b0;
            end
            if (prev_ok && same) begin
                conv = 1'b1;
                break;
            end
            for (int j = 0; j < k; j++) begin
                px[j] = ctr_x[j];
                py[j] = ctr_y[j];
            end
            prev_ok = 1'b1;
            if (passes >= lim) break;
        end
        for (int i = 0; i < pt_n; i++) begin
            r = '{1'b0, 6'(i), pt_cl[i], 16'd0, 16'd0, conv, 8'(passes), 1'b0};
            pending_results = {pending_results, r};
        end
        for (int j = 0; j < k; j++) begin
            r = '{1'b1, 6'(j), 3'd0, ctr_x[j], ctr_y[j], conv, 8'(passes), j == k - 1};
            pending_results = {pending_results, r};
        end
    endtask

    task automatic model_beat(logic [1:0] func, logic [2:0] slot,
                              logic [15:0] x, logic [15:0] y);
        case (func)
            kmc_pkg::FUNC_LOAD_POINT: begin
                if (pt_n < kmc_pkg::MAX_POINTS) begin
                    pt_x[pt_n] = x;
                    pt_y[pt_n] = y;
                    pt_n++;
                    useful_beats++;
                end
            end
            kmc_pkg::FUNC_LOAD_SEED: begin
                ctr_x[slot] = x;
                ctr_y[slot] = y;
                useful_beats++;
            end
            kmc_pkg::FUNC_START: begin
                predict_clustering();
                useful_beats++;
            end
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one beat, hold it until accepted, then idle a random gap
    task automatic send_beat(logic [1:0] func, logic [2:0] slot,
                             logic [15:0] x, logic [15:0] y);
        int gap;
        i_valid <= 1'b1;
        i_func <= func;
        i_slot <= slot;
        i_coord_x <= x;
        i_coord_y <= y;
        do @(posedge i_clk); while (!o_ready);
        model_beat(func, slot, x, y);
        gap = pick_gap();
        valid_held = (gap == 0);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and let all results and queued loads drain
    task automatic wait_idle();
        if (valid_held) begin
            i_valid <= 1'b0;
            valid_held = 1'b0;
        end
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] index, logic [7:0] value);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == kmc_pkg::REG_CLUSTER_COUNT) k_reg = value[3:0];
        else limit_reg = value;
    endtask

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // Check each result beat against the oldest expectation, then drive ready
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_result want;
        if (o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected beat", 32'd1, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_kind !== want.kind) report("kind", o_kind, want.kind);
                if (o_item_index !== want.idx) report("item_index", o_item_index, want.idx);
                if (o_cluster_id !== want.cid) report("cluster_id", o_cluster_id, want.cid);
                if (o_centre_x !== want.cx) report("centre_x", o_centre_x, want.cx);
                if (o_centre_y !== want.cy) report("centre_y", o_centre_y, want.cy);
                if (o_converged !== want.conv) report("converged", o_converged, want.conv);
                if (o_passes_used !== want.passes)
                    report("passes_used", o_passes_used, want.passes);
                if (o_last !== want.last) report("last", o_last, want.last);
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 25) stall_left = pick_gap();
        end
    end

    // Watchdog: end the run when nothing moves for too long
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [15:0] rand_coord(logic [15:0] base);
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return 16'($urandom);
        if (r < 28) return (r < 24) ? 16'h0000 : 16'hFFFF;
        return base + 16'($urandom_range(0, 255));
    endfunction

    // No points loaded, unused code, seed above the cluster count
    task automatic test_empty_set();
        send_beat(FUNC_UNUSED, 3'd7, 16'hFFFF, 16'hFFFF);
        send_beat(kmc_pkg::FUNC_LOAD_SEED, 3'd7, 16'h1234, 16'hABCD);
        send_beat(kmc_pkg::FUNC_START, 3'd0, 16'd0, 16'd0);
    endtask

    // Extreme coordinates and register clamping, then a repeated start
    task automatic test_extremes();
        write_reg(kmc_pkg::REG_CLUSTER_COUNT, 8'd0);
        write_reg(kmc_pkg::REG_MAX_PASSES, 8'd0);
        send_beat(kmc_pkg::FUNC_LOAD_POINT, 3'd5, 16'h0000, 16'h0000);
        send_beat(kmc_pkg::FUNC_LOAD_POINT, 3'd2, 16'hFFFF, 16'hFFFF);
        send_beat(kmc_pkg::FUNC_LOAD_POINT, 3'd0, 16'hFFFF, 16'h0000);
        send_beat(kmc_pkg::FUNC_START, 3'd7, 16'hFFFF, 16'hFFFF);
        write_reg(kmc_pkg::REG_CLUSTER_COUNT, 8'd15);
        write_reg(kmc_pkg::REG_MAX_PASSES, 8'd255);
        send_beat(kmc_pkg::FUNC_LOAD_SEED, 3'd1, 16'hFFFF, 16'hFFFF);
        send_beat(kmc_pkg::FUNC_START, 3'd0, 16'd0, 16'd0);
    endtask

    // Equal distances go to the lower index; repeat on the last allowed pass
    task automatic test_ties();
        write_reg(kmc_pkg::REG_CLUSTER_COUNT, 8'd2);
        write_reg(kmc_pkg::REG_MAX_PASSES, 8'd2);
        send_beat(kmc_pkg::FUNC_LOAD_SEED, 3'd0, 16'd8, 16'd8);
        send_beat(kmc_pkg::FUNC_LOAD_SEED, 3'd1, 16'd8, 16'd8);
        send_beat(kmc_pkg::FUNC_LOAD_POINT, 3'd0, 16'd16, 16'd16);
        send_beat(kmc_pkg::FUNC_START, 3'd0, 16'd0, 16'd0);
        send_beat(kmc_pkg::FUNC_LOAD_SEED, 3'd0, 16'd0, 16'd0);
        send_beat(kmc_pkg::FUNC_LOAD_SEED, 3'd1, 16'd32, 16'd32);
        send_beat(kmc_pkg::FUNC_START, 3'd0, 16'd0, 16'd0);
    endtask

    // Hold the result side off while starts and loads keep coming
    task automatic test_backpressure();
        write_reg(kmc_pkg::REG_CLUSTER_COUNT, 8'd3);
        write_reg(kmc_pkg::REG_MAX_PASSES, 8'd6);
        hold_cycles = 4000;
        calm = 1'b1;
        send_beat(kmc_pkg::FUNC_START, 3'd0, 16'd0, 16'd0);
        for (int i = 0; i < 10; i++)
            send_beat(i % 3 == 0 ? kmc_pkg::FUNC_START : kmc_pkg::FUNC_LOAD_POINT,
                      3'($urandom), rand_coord(16'h4000), rand_coord(16'h8000));
        calm = 1'b0;
    endtask

    task automatic test_random();
        logic [15:0] bases_x [4];
        logic [15:0] bases_y [4];
        int          r;
        int          b;
        int          lim;
        int          target;
        target = useful_beats + 200;
        for (int i = 0; i < 4; i++) begin
            bases_x[i] = 16'($urandom);
            bases_y[i] = 16'($urandom);
        end
        while (useful_beats < target) begin
            if ($urandom_range(0, 29) == 0) calm = !calm;
            r = $urandom_range(0, 99);
            b = $urandom_range(0, 3);
            if (r < 45) begin
                send_beat(kmc_pkg::FUNC_LOAD_POINT, 3'($urandom),
                          rand_coord(bases_x[b]), rand_coord(bases_y[b]));
            end else if (r < 68) begin
                send_beat(kmc_pkg::FUNC_LOAD_SEED, 3'($urandom),
                          rand_coord(bases_x[b]), rand_coord(bases_y[b]));
            end else if (r < 73) begin
                send_beat(FUNC_UNUSED, 3'($urandom), 16'($urandom), 16'($urandom));
            end else if (r < 88) begin
                if ($urandom_range(0, 9) < 4) begin
                    write_reg(kmc_pkg::REG_CLUSTER_COUNT, 8'($urandom_range(0, 15)));
                    lim = $urandom_range(0, 19);
                    lim = (lim < 16) ? $urandom_range(1, 8) :
                          (lim < 18) ? 0 : 255;
                    write_reg(kmc_pkg::REG_MAX_PASSES, 8'(lim));
                end
                send_beat(kmc_pkg::FUNC_START, 3'($urandom), 16'($urandom), 16'($urandom));
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_set();
        test_extremes();
        test_ties();
        test_backpressure();
        test_random();
        wait_idle();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
